>>> hdl/cht_pkg.sv
// shared constants, codes and controller/datapath interface types for the hash table
package cht_pkg;

    // table geometry
    localparam int TABLE_SLOTS  = 64;
    localparam int HOME_BUCKETS = 5;
    localparam int KEY_BITS     = 16;
    localparam int SLOT_BITS    = $clog2(TABLE_SLOTS);
    localparam int LINK_BITS    = $clog2(TABLE_SLOTS + 1);
    localparam logic [LINK_BITS-1:0] LINK_END = LINK_BITS'(TABLE_SLOTS);

    // item field widths
    localparam int FUNC_W     = 2;
    localparam int IN_KEY_W   = 16;
    localparam int STATUS_W   = 3;
    localparam int OUT_SLOT_W = 6;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 8;

    // home slot by reciprocal multiply: quotient = (key * recip) >> shift
    localparam int HASH_SHIFT = KEY_BITS + 7;
    localparam int PROD_BITS  = KEY_BITS + HASH_SHIFT + 1;
    localparam logic [PROD_BITS-1:0] HOME_RECIP =
        PROD_BITS'(((64'd1 << HASH_SHIFT) / HOME_BUCKETS) + 64'd1);

    // operations
    localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FN_SEARCH = 2'd1;
    localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd2;

    // result status
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd4;
    localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd5;

    // slot occupancy
    localparam logic [1:0] MARK_EMPTY   = 2'd0;
    localparam logic [1:0] MARK_USED    = 2'd1;
    localparam logic [1:0] MARK_DELETED = 2'd2;

    // read address select
    localparam logic [2:0] RA_CUR      = 3'd0;
    localparam logic [2:0] RA_HOME     = 3'd1;
    localparam logic [2:0] RA_ZERO     = 3'd2;
    localparam logic [2:0] RA_IDX_NEXT = 3'd3;
    localparam logic [2:0] RA_LINK     = 3'd4;

    // write kinds
    localparam logic [1:0] WK_HOME  = 2'd0;
    localparam logic [1:0] WK_TAIL  = 2'd1;
    localparam logic [1:0] WK_FRESH = 2'd2;
    localparam logic [1:0] WK_DEL   = 2'd3;

    // result slot source
    localparam logic [2:0] SS_ZERO  = 3'd0;
    localparam logic [2:0] SS_CUR   = 3'd1;
    localparam logic [2:0] SS_IDX   = 3'd2;
    localparam logic [2:0] SS_FRESH = 3'd3;
    localparam logic [2:0] SS_FIRST = 3'd4;

    // one table entry
    typedef struct packed {
        logic [KEY_BITS-1:0]  key;
        logic [1:0]           mark;
        logic [LINK_BITS-1:0] link;
    } entry_t;

    // controller to datapath
    typedef struct packed {
        logic                load;
        logic                hash;
        logic                cur_home;
        logic                cur_link;
        logic                idx_top;
        logic                idx_clr;
        logic                idx_inc;
        logic                idx_dec;
        logic                fresh_ld;
        logic                rem_clr;
        logic                rem_upd;
        logic                rd;
        logic [2:0]          rd_sel;
        logic                wr;
        logic [1:0]          wr_kind;
        logic                res_ld;
        logic [STATUS_W-1:0] res_status;
        logic [2:0]          res_src;
        logic                push;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              used;
        logic              link_end;
        logic              idx_free;
        logic              idx_zero;
        logic              idx_last;
        logic              hit;
        logic              any;
        logic              removed_any;
        logic              out_free;
    } sts_t;

endpackage

>>> hdl/cht_dp.sv
// hash table datapath: slot memory, valid bits, hash, counters and result register
module cht_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cht_pkg::cmd_t                 cmd,
    output cht_pkg::sts_t                 sts,
    input  logic [cht_pkg::FUNC_W-1:0]    in_func,
    input  logic [cht_pkg::IN_KEY_W-1:0]  in_key,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [cht_pkg::STATUS_W-1:0]  out_status,
    output logic [cht_pkg::OUT_SLOT_W-1:0] out_slot
);

    // slot memory and per-slot written bits
    cht_pkg::entry_t mem [cht_pkg::TABLE_SLOTS];
    logic [cht_pkg::TABLE_SLOTS-1:0] vld_reg;
    logic [cht_pkg::TABLE_SLOTS-1:0] vld_next;
    cht_pkg::entry_t rdata_reg;
    logic            rvld_reg;
    logic            rvld_next;

    // item and walk registers
    logic [cht_pkg::FUNC_W-1:0]    func_reg;
    logic [cht_pkg::KEY_BITS-1:0]  key_reg;
    logic [cht_pkg::PROD_BITS-1:0] prod_reg;
    logic [cht_pkg::KEY_BITS-1:0]  qb_reg;
    logic [cht_pkg::LINK_BITS-1:0] cur_reg;
    logic [cht_pkg::SLOT_BITS-1:0] idx_reg;
    logic [cht_pkg::SLOT_BITS-1:0] fresh_reg;
    logic [cht_pkg::SLOT_BITS-1:0] first_reg;
    logic                          removed_reg;
    logic                          any_reg;

    // result holding and output registers
    logic [cht_pkg::STATUS_W-1:0]   res_status_reg;
    logic [cht_pkg::OUT_SLOT_W-1:0] res_slot_reg;
    logic [cht_pkg::STATUS_W-1:0]   out_status_reg;
    logic [cht_pkg::OUT_SLOT_W-1:0] out_slot_reg;
    logic                           out_valid_reg;
    logic                           out_valid_next;

    logic [cht_pkg::KEY_BITS:0]     quot;
    logic [cht_pkg::KEY_BITS-1:0]   rem;
    logic [cht_pkg::SLOT_BITS-1:0]  home;
    logic [1:0]                     e_mark;
    logic [cht_pkg::LINK_BITS-1:0]  e_link;
    logic                           used;
    logic                           hit;
    logic [cht_pkg::SLOT_BITS-1:0]  cur_slot;
    logic [cht_pkg::SLOT_BITS-1:0]  raddr;
    logic [cht_pkg::SLOT_BITS-1:0]  waddr;
    cht_pkg::entry_t                wdata;
    logic [cht_pkg::SLOT_BITS-1:0]  res_slot;

    // home slot from the registered quotient
    assign quot = prod_reg[cht_pkg::PROD_BITS-1:cht_pkg::HASH_SHIFT];
    assign rem  = key_reg - qb_reg;
    assign home = (rem >= cht_pkg::KEY_BITS'(cht_pkg::TABLE_SLOTS))
                ? cht_pkg::SLOT_BITS'(rem - cht_pkg::KEY_BITS'(cht_pkg::TABLE_SLOTS))
                : cht_pkg::SLOT_BITS'(rem);

    // entry as read, never-written slots read as empty end-of-chain
    assign e_mark   = rvld_reg ? rdata_reg.mark : cht_pkg::MARK_EMPTY;
    assign e_link   = rvld_reg ? rdata_reg.link : cht_pkg::LINK_END;
    assign used     = (e_mark == cht_pkg::MARK_USED);
    assign hit      = used && (rdata_reg.key == key_reg);
    assign cur_slot = cur_reg[cht_pkg::SLOT_BITS-1:0];

    // read address select
    always_comb
    begin
        unique case (cmd.rd_sel)
            cht_pkg::RA_CUR:      raddr = cur_slot;
            cht_pkg::RA_HOME:     raddr = home;
            cht_pkg::RA_ZERO:     raddr = '0;
            cht_pkg::RA_IDX_NEXT: raddr = idx_reg + cht_pkg::SLOT_BITS'(1);
            cht_pkg::RA_LINK:     raddr = e_link[cht_pkg::SLOT_BITS-1:0];
            default:              raddr = '0;
        endcase
    end

    // write address and data
    always_comb
    begin
        waddr = cur_slot;
        unique case (cmd.wr_kind)
            cht_pkg::WK_HOME:
            begin
                wdata = '{key: key_reg, mark: cht_pkg::MARK_USED, link: e_link};
            end
            cht_pkg::WK_TAIL:
            begin
                wdata = '{key: rdata_reg.key, mark: rdata_reg.mark,
                          link: cht_pkg::LINK_BITS'(fresh_reg)};
            end
            cht_pkg::WK_FRESH:
            begin
                waddr = fresh_reg;
                wdata = '{key: key_reg, mark: cht_pkg::MARK_USED, link: cht_pkg::LINK_END};
            end
            cht_pkg::WK_DEL:
            begin
                wdata = '{key: rdata_reg.key, mark: cht_pkg::MARK_DELETED,
                          link: rdata_reg.link};
            end
        endcase
    end

    // slot memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            mem[waddr] <= wdata;
        end
        if (cmd.rd)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    // written bits and output valid
    always_comb
    begin
        vld_next = vld_reg;
        if (cmd.wr)
        begin
            vld_next[waddr] = 1'b1;
        end
        rvld_next = rvld_reg;
        if (cmd.rd)
        begin
            rvld_next = vld_reg[raddr];
        end
        out_valid_next = out_valid_reg;
        if (cmd.push)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            rvld_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            vld_reg       <= vld_next;
            rvld_reg      <= rvld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result slot select
    always_comb
    begin
        unique case (cmd.res_src)
            cht_pkg::SS_ZERO:  res_slot = '0;
            cht_pkg::SS_CUR:   res_slot = cur_slot;
            cht_pkg::SS_IDX:   res_slot = idx_reg;
            cht_pkg::SS_FRESH: res_slot = fresh_reg;
            cht_pkg::SS_FIRST: res_slot = removed_reg ? first_reg : cur_slot;
            default:           res_slot = '0;
        endcase
    end

    // item, hash, walk and scan registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= in_func;
            key_reg  <= cht_pkg::KEY_BITS'(in_key);
            prod_reg <= cht_pkg::PROD_BITS'(in_key) * cht_pkg::HOME_RECIP;
        end
        if (cmd.hash)
        begin
            qb_reg <= cht_pkg::KEY_BITS'(quot * cht_pkg::HOME_BUCKETS);
        end
        if (cmd.cur_home)
        begin
            cur_reg <= cht_pkg::LINK_BITS'(home);
        end
        else if (cmd.cur_link)
        begin
            cur_reg <= e_link;
        end
        if (cmd.idx_top)
        begin
            idx_reg <= cht_pkg::SLOT_BITS'(cht_pkg::TABLE_SLOTS - 1);
        end
        else if (cmd.idx_clr)
        begin
            idx_reg <= '0;
            any_reg <= 1'b0;
        end
        else if (cmd.idx_inc)
        begin
            idx_reg <= idx_reg + cht_pkg::SLOT_BITS'(1);
            any_reg <= any_reg | used;
        end
        else if (cmd.idx_dec)
        begin
            idx_reg <= idx_reg - cht_pkg::SLOT_BITS'(1);
        end
        if (cmd.fresh_ld)
        begin
            fresh_reg <= idx_reg;
        end
        if (cmd.rem_clr)
        begin
            removed_reg <= 1'b0;
        end
        else if (cmd.rem_upd)
        begin
            removed_reg <= 1'b1;
            if (!removed_reg)
            begin
                first_reg <= cur_slot;
            end
        end
        if (cmd.res_ld)
        begin
            res_status_reg <= cmd.res_status;
            res_slot_reg   <= cht_pkg::OUT_SLOT_W'(res_slot);
        end
        if (cmd.push)
        begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= res_slot_reg;
        end
    end

    // status to the controller
    assign sts.func        = func_reg;
    assign sts.used        = used;
    assign sts.link_end    = (e_link >= cht_pkg::LINK_END);
    assign sts.idx_free    = !vld_reg[idx_reg];
    assign sts.idx_zero    = (idx_reg == '0);
    assign sts.idx_last    = (idx_reg == cht_pkg::SLOT_BITS'(cht_pkg::TABLE_SLOTS - 1));
    assign sts.hit         = hit;
    assign sts.any         = any_reg | used;
    assign sts.removed_any = removed_reg | hit;
    assign sts.out_free    = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_slot   = out_slot_reg;

endmodule

>>> hdl/cht_ctrl.sv
// hash table controller: sequences hash, scans and chain walks for one item at a time
module cht_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  cht_pkg::sts_t sts,
    output cht_pkg::cmd_t cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_HASH     = 4'd1;
    localparam logic [3:0] S_DISPATCH = 4'd2;
    localparam logic [3:0] S_INS_HOME = 4'd3;
    localparam logic [3:0] S_FREE     = 4'd4;
    localparam logic [3:0] S_WALK     = 4'd5;
    localparam logic [3:0] S_FRESH    = 4'd6;
    localparam logic [3:0] S_SCAN     = 4'd7;
    localparam logic [3:0] S_RWALK    = 4'd8;
    localparam logic [3:0] S_RESP     = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    // next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                cmd.hash   = 1'b1;
                state_next = S_DISPATCH;
            end
            S_DISPATCH:
            begin
                cmd.cur_home = 1'b1;
                unique case (sts.func)
                    cht_pkg::FN_INSERT:
                    begin
                        cmd.rd     = 1'b1;
                        cmd.rd_sel = cht_pkg::RA_HOME;
                        state_next = S_INS_HOME;
                    end
                    cht_pkg::FN_SEARCH, cht_pkg::FN_REMOVE:
                    begin
                        cmd.rd      = 1'b1;
                        cmd.rd_sel  = cht_pkg::RA_ZERO;
                        cmd.idx_clr = 1'b1;
                        state_next  = S_SCAN;
                    end
                    default:
                    begin
                        cmd.res_ld     = 1'b1;
                        cmd.res_status = cht_pkg::ST_NOT_FOUND;
                        cmd.res_src    = cht_pkg::SS_ZERO;
                        state_next     = S_RESP;
                    end
                endcase
            end
            // home slot free or deleted: take it over
            S_INS_HOME:
            begin
                if (!sts.used)
                begin
                    cmd.wr         = 1'b1;
                    cmd.wr_kind    = cht_pkg::WK_HOME;
                    cmd.res_ld     = 1'b1;
                    cmd.res_status = cht_pkg::ST_INSERTED;
                    cmd.res_src    = cht_pkg::SS_CUR;
                    state_next     = S_RESP;
                end
                else
                begin
                    cmd.idx_top = 1'b1;
                    state_next  = S_FREE;
                end
            end
            // search down for the highest never-used slot
            S_FREE:
            begin
                priority if (sts.idx_free)
                begin
                    cmd.fresh_ld = 1'b1;
                    cmd.rd       = 1'b1;
                    cmd.rd_sel   = cht_pkg::RA_CUR;
                    state_next   = S_WALK;
                end
                else if (sts.idx_zero)
                begin
                    cmd.res_ld     = 1'b1;
                    cmd.res_status = cht_pkg::ST_OVERFLOW;
                    cmd.res_src    = cht_pkg::SS_ZERO;
                    state_next     = S_RESP;
                end
                else
                begin
                    cmd.idx_dec = 1'b1;
                end
            end
            // follow the home chain to its tail and link the new slot
            S_WALK:
            begin
                if (!sts.link_end)
                begin
                    cmd.cur_link = 1'b1;
                    cmd.rd       = 1'b1;
                    cmd.rd_sel   = cht_pkg::RA_LINK;
                end
                else
                begin
                    cmd.wr      = 1'b1;
                    cmd.wr_kind = cht_pkg::WK_TAIL;
                    state_next  = S_FRESH;
                end
            end
            S_FRESH:
            begin
                cmd.wr         = 1'b1;
                cmd.wr_kind    = cht_pkg::WK_FRESH;
                cmd.res_ld     = 1'b1;
                cmd.res_status = cht_pkg::ST_INSERTED;
                cmd.res_src    = cht_pkg::SS_FRESH;
                state_next     = S_RESP;
            end
            // full scan, one slot per cycle, stops at the first match
            S_SCAN:
            begin
                priority if (sts.hit)
                begin
                    if (sts.func == cht_pkg::FN_SEARCH)
                    begin
                        cmd.res_ld     = 1'b1;
                        cmd.res_status = cht_pkg::ST_FOUND;
                        cmd.res_src    = cht_pkg::SS_IDX;
                        state_next     = S_RESP;
                    end
                    else
                    begin
                        cmd.rem_clr = 1'b1;
                        cmd.rd      = 1'b1;
                        cmd.rd_sel  = cht_pkg::RA_CUR;
                        state_next  = S_RWALK;
                    end
                end
                else if (sts.idx_last)
                begin
                    cmd.res_ld  = 1'b1;
                    cmd.res_src = cht_pkg::SS_ZERO;
                    if (sts.func == cht_pkg::FN_REMOVE && !sts.any)
                    begin
                        cmd.res_status = cht_pkg::ST_UNDERFLOW;
                    end
                    else
                    begin
                        cmd.res_status = cht_pkg::ST_NOT_FOUND;
                    end
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    cmd.rd      = 1'b1;
                    cmd.rd_sel  = cht_pkg::RA_IDX_NEXT;
                end
            end
            // mark every match on the home chain as deleted
            S_RWALK:
            begin
                if (sts.hit)
                begin
                    cmd.wr      = 1'b1;
                    cmd.wr_kind = cht_pkg::WK_DEL;
                    cmd.rem_upd = 1'b1;
                end
                if (!sts.link_end)
                begin
                    cmd.cur_link = 1'b1;
                    cmd.rd       = 1'b1;
                    cmd.rd_sel   = cht_pkg::RA_LINK;
                end
                else
                begin
                    cmd.res_ld = 1'b1;
                    if (sts.removed_any)
                    begin
                        cmd.res_status = cht_pkg::ST_REMOVED;
                        cmd.res_src    = cht_pkg::SS_FIRST;
                    end
                    else
                    begin
                        cmd.res_status = cht_pkg::ST_NOT_FOUND;
                        cmd.res_src    = cht_pkg::SS_ZERO;
                    end
                    state_next = S_RESP;
                end
            end
            // hand the result to the output register when it is free
            S_RESP:
            begin
                if (sts.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hdl/coalesced_hash_table.sv
// coalesced-chaining hash table: one insert, search or remove per item, one result item each
// search reads the slots in turn (one slot read per cycle) until the first match; insert
// fills a free home slot, or else runs the free-slot search and chain walk; remove does
// a scan, then a home chain walk
// throughput: one item at a time; the next item is taken while a result waits for tready
// reset clears the controller, output valid and per-slot written bits; no clearing pass
module coalesced_hash_table (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [cht_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // [15:0] key
    input  logic [cht_pkg::FUNC_W-1:0]       s_axis_tuser,  // [1:0] func
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [cht_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // [5:0] slot, [7:6] zero
    output logic [cht_pkg::STATUS_W-1:0]     m_axis_tuser   // [2:0] status
);

    cht_pkg::cmd_t                  cmd;
    cht_pkg::sts_t                  sts;
    logic [cht_pkg::OUT_SLOT_W-1:0] out_slot;

    // sequencing
    cht_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // table storage and arithmetic
    cht_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_func    (s_axis_tuser),
        .in_key     (s_axis_tdata[cht_pkg::IN_KEY_W-1:0]),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_status (m_axis_tuser),
        .out_slot   (out_slot)
    );

    // slot in the low bits, zero fill above
    assign m_axis_tdata = cht_pkg::OUT_DATA_W'(out_slot);

endmodule

>>> tb/tb_coalesced_hash_table.sv
// self-checking testbench for the coalesced-chaining hash table: directed table, then random items
module tb_coalesced_hash_table;

    // func value with no operation behind it
    localparam logic [cht_pkg::FUNC_W-1:0] FN_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS   = 1526;
    localparam int SETTLE_CYCLES  = 150;
    localparam int DIRECTED_ROWS  = 24;

    // one result item: status and slot
    typedef struct packed {
        logic [cht_pkg::STATUS_W-1:0]   status;
        logic [cht_pkg::OUT_SLOT_W-1:0] slot;
    } outcome_t;

    // one row of the directed table; fixed rows carry their result typed in
    typedef struct {
        logic [cht_pkg::FUNC_W-1:0]     func;
        logic [cht_pkg::IN_KEY_W-1:0]   key;
        bit                             fixed;
        logic [cht_pkg::STATUS_W-1:0]   status;
        logic [cht_pkg::OUT_SLOT_W-1:0] slot;
    } table_row_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [cht_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [cht_pkg::FUNC_W-1:0]     s_axis_tuser = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [cht_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic [cht_pkg::STATUS_W-1:0]   m_axis_tuser;

    // shadow copy of the table contents
    logic [cht_pkg::KEY_BITS-1:0]   shadow_key  [cht_pkg::TABLE_SLOTS];
    logic [1:0]                     shadow_mark [cht_pkg::TABLE_SLOTS];
    logic [cht_pkg::LINK_BITS-1:0]  shadow_link [cht_pkg::TABLE_SLOTS];

    outcome_t                       awaited_results[$];
    logic [cht_pkg::IN_KEY_W-1:0]   stored_keys[$];
    int                             error_count = 0;
    int                             items_sent = 0;
    int                             status_seen[8];
    int                             send_idle_pct = 18;
    int                             recv_idle_pct = 68;

    table_row_t directed_rows[DIRECTED_ROWS] = '{
        '{cht_pkg::FN_REMOVE, 16'h0000, 1'b1, cht_pkg::ST_UNDERFLOW, 6'd0},
        '{cht_pkg::FN_SEARCH, 16'hFFFF, 1'b1, cht_pkg::ST_NOT_FOUND, 6'd0},
        '{FN_UNUSED,          16'hAAAA, 1'b1, cht_pkg::ST_NOT_FOUND, 6'd0},
        '{cht_pkg::FN_INSERT, 16'h0000, 1'b1, cht_pkg::ST_INSERTED,  6'd0},
        '{cht_pkg::FN_INSERT, 16'hFFFF, 1'b1, cht_pkg::ST_INSERTED,  6'd63},
        '{cht_pkg::FN_INSERT, 16'd5,    1'b1, cht_pkg::ST_INSERTED,  6'd62},
        '{cht_pkg::FN_INSERT, 16'hFFFF, 1'b0, cht_pkg::ST_INSERTED,  6'd0},
        '{cht_pkg::FN_SEARCH, 16'hFFFF, 1'b1, cht_pkg::ST_FOUND,     6'd61},
        '{cht_pkg::FN_REMOVE, 16'hFFFF, 1'b0, cht_pkg::ST_INSERTED,  6'd0},
        '{cht_pkg::FN_SEARCH, 16'hFFFF, 1'b1, cht_pkg::ST_NOT_FOUND, 6'd0},
        '{cht_pkg::FN_REMOVE, 16'h0000, 1'b0, cht_pkg::ST_INSERTED,  6'd0},
        '{cht_pkg::FN_INSERT, 16'd10,   1'b1, cht_pkg::ST_INSERTED,  6'd0},
        '{cht_pkg::FN_INSERT, 16'd20,   1'b0, cht_pkg::ST_INSERTED,  6'd0},
        '{cht_pkg::FN_REMOVE, 16'd3,    1'b1, cht_pkg::ST_NOT_FOUND, 6'd0},
        '{cht_pkg::FN_INSERT, 16'h5555, 1'b0, cht_pkg::ST_INSERTED,  6'd0},
        '{cht_pkg::FN_INSERT, 16'hAAAA, 1'b0, cht_pkg::ST_INSERTED,  6'd0},
        '{FN_UNUSED,          16'h5555, 1'b1, cht_pkg::ST_NOT_FOUND, 6'd0},
        '{cht_pkg::FN_INSERT, 16'd1,    1'b0, cht_pkg::ST_INSERTED,  6'd0},
        '{cht_pkg::FN_INSERT, 16'd6,    1'b0, cht_pkg::ST_INSERTED,  6'd0},
        '{cht_pkg::FN_REMOVE, 16'd6,    1'b0, cht_pkg::ST_INSERTED,  6'd0},
        '{cht_pkg::FN_INSERT, 16'd11,   1'b0, cht_pkg::ST_INSERTED,  6'd0},
        '{cht_pkg::FN_SEARCH, 16'd11,   1'b0, cht_pkg::ST_INSERTED,  6'd0},
        '{cht_pkg::FN_REMOVE, 16'd1,    1'b0, cht_pkg::ST_INSERTED,  6'd0},
        '{cht_pkg::FN_INSERT, 16'd4,    1'b0, cht_pkg::ST_INSERTED,  6'd0}
    };

    coalesced_hash_table dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    // applies one operation to the shadow table and returns its result item
    function automatic outcome_t hash_table_apply(input logic [cht_pkg::FUNC_W-1:0] func,
                                                  input logic [cht_pkg::KEY_BITS-1:0] k);
        int       home;
        int       fresh;
        int       cur;
        int       steps;
        int       first;
        bit       any_used;
        bit       present;
        bit       removed;
        outcome_t res;
        res.status = cht_pkg::ST_NOT_FOUND;
        res.slot   = '0;
        home = (int'(k) % cht_pkg::HOME_BUCKETS) % cht_pkg::TABLE_SLOTS;
        unique case (func)
            cht_pkg::FN_INSERT:
            begin
                if (shadow_mark[home] != cht_pkg::MARK_USED)
                begin
                    // unused or deleted home slot: take it, keep its link
                    shadow_key[home]  = k;
                    shadow_mark[home] = cht_pkg::MARK_USED;
                    res.status = cht_pkg::ST_INSERTED;
                    res.slot   = cht_pkg::OUT_SLOT_W'(home);
                end
                else
                begin
                    fresh = cht_pkg::TABLE_SLOTS;
                    for (int i = cht_pkg::TABLE_SLOTS - 1; i >= 0; i--)
                    begin
                        if (shadow_mark[i] == cht_pkg::MARK_EMPTY)
                        begin
                            fresh = i;
                            break;
                        end
                    end
                    if (fresh == cht_pkg::TABLE_SLOTS)
                    begin
                        res.status = cht_pkg::ST_OVERFLOW;
                    end
                    else
                    begin
                        // walk to the chain tail and append the fresh slot
                        cur   = home;
                        steps = 0;
                        while (shadow_link[cur] != cht_pkg::LINK_END &&
                               steps < cht_pkg::TABLE_SLOTS)
                        begin
                            cur = int'(shadow_link[cur]);
                            steps++;
                        end
                        shadow_link[cur]   = cht_pkg::LINK_BITS'(fresh);
                        shadow_key[fresh]  = k;
                        shadow_mark[fresh] = cht_pkg::MARK_USED;
                        shadow_link[fresh] = cht_pkg::LINK_END;
                        res.status = cht_pkg::ST_INSERTED;
                        res.slot   = cht_pkg::OUT_SLOT_W'(fresh);
                    end
                end
            end
            cht_pkg::FN_SEARCH:
            begin
                for (int i = 0; i < cht_pkg::TABLE_SLOTS; i++)
                begin
                    if (shadow_mark[i] == cht_pkg::MARK_USED && shadow_key[i] == k)
                    begin
                        res.status = cht_pkg::ST_FOUND;
                        res.slot   = cht_pkg::OUT_SLOT_W'(i);
                        break;
                    end
                end
            end
            cht_pkg::FN_REMOVE:
            begin
                any_used = 1'b0;
                present  = 1'b0;
                for (int i = 0; i < cht_pkg::TABLE_SLOTS; i++)
                begin
                    if (shadow_mark[i] == cht_pkg::MARK_USED)
                    begin
                        any_used = 1'b1;
                        if (shadow_key[i] == k)
                            present = 1'b1;
                    end
                end
                if (!any_used)
                begin
                    res.status = cht_pkg::ST_UNDERFLOW;
                end
                else if (present)
                begin
                    // mark every match along the home chain, links stay
                    cur     = home;
                    steps   = 0;
                    first   = 0;
                    removed = 1'b0;
                    while (cur < cht_pkg::TABLE_SLOTS && steps <= cht_pkg::TABLE_SLOTS)
                    begin
                        if (shadow_mark[cur] == cht_pkg::MARK_USED && shadow_key[cur] == k)
                        begin
                            shadow_mark[cur] = cht_pkg::MARK_DELETED;
                            if (!removed)
                                first = cur;
                            removed = 1'b1;
                        end
                        cur = int'(shadow_link[cur]);
                        steps++;
                    end
                    if (removed)
                    begin
                        res.status = cht_pkg::ST_REMOVED;
                        res.slot   = cht_pkg::OUT_SLOT_W'(first);
                    end
                end
            end
            default:
            begin
                res.status = cht_pkg::ST_NOT_FOUND;
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // offers one item, waits for it to be taken and records its expected result
    task automatic send_item(input logic [cht_pkg::FUNC_W-1:0] func,
                             input logic [cht_pkg::IN_KEY_W-1:0] key,
                             input bit fixed, input outcome_t typed);
        outcome_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= key;
        s_axis_tuser  <= func;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predicted = hash_table_apply(func, key);
        awaited_results.push_back(fixed ? typed : predicted);
        if (func == cht_pkg::FN_INSERT && predicted.status == cht_pkg::ST_INSERTED)
        begin
            stored_keys.push_back(key);
            if (stored_keys.size() > cht_pkg::TABLE_SLOTS)
                void'(stored_keys.pop_front());
        end
        items_sent++;
        @(negedge clk);
    endtask

    // random item: mostly keys already stored or small colliding keys
    task automatic send_random(input int insert_pct);
        logic [cht_pkg::FUNC_W-1:0]   func;
        logic [cht_pkg::IN_KEY_W-1:0] key;
        int                           pick;
        pick = $urandom_range(0, 99);
        if (pick < insert_pct)
            func = cht_pkg::FN_INSERT;
        else if (pick < insert_pct + (97 - insert_pct) / 2)
            func = cht_pkg::FN_SEARCH;
        else if (pick < 97)
            func = cht_pkg::FN_REMOVE;
        else
            func = FN_UNUSED;
        pick = $urandom_range(0, 99);
        if (stored_keys.size() != 0 && pick < (func == cht_pkg::FN_INSERT ? 30 : 70))
            key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
        else if (pick < 85)
            key = cht_pkg::IN_KEY_W'($urandom_range(0, 24));
        else
            key = cht_pkg::IN_KEY_W'($urandom_range(0, 65535));
        send_item(func, key, 1'b0, '0);
    endtask

    // holds the sender off until every expected result has come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (awaited_results.size() != 0)
            @(negedge clk);
    endtask

    // receiver stalls
    always @(negedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // result check against the oldest expectation
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            status_seen[m_axis_tuser]++;
            if (awaited_results.size() == 0)
            begin
                report_mismatch("result item with none expected, status", m_axis_tuser, 0);
            end
            else
            begin
                want = awaited_results.pop_front();
                if (m_axis_tuser != want.status)
                    report_mismatch("status", m_axis_tuser, want.status);
                if (m_axis_tdata != cht_pkg::OUT_DATA_W'(want.slot))
                    report_mismatch("slot", m_axis_tdata, want.slot);
            end
        end
    end

    // stimulus
    initial
    begin
        int insert_pct;
        for (int i = 0; i < cht_pkg::TABLE_SLOTS; i++)
        begin
            shadow_key[i]  = '0;
            shadow_mark[i] = cht_pkg::MARK_EMPTY;
            shadow_link[i] = cht_pkg::LINK_END;
        end
        for (int i = 0; i < 8; i++)
            status_seen[i] = 0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int phase = 0; phase < 3; phase++)
        begin
            unique case (phase)
                0:
                begin
                    send_idle_pct = 18;
                    recv_idle_pct = 68;
                    insert_pct    = 8;
                end
                1:
                begin
                    send_idle_pct = 68;
                    recv_idle_pct = 18;
                    insert_pct    = 10;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    insert_pct    = 30;
                end
            endcase
            if (phase == 0)
            begin
                foreach (directed_rows[r])
                    send_item(directed_rows[r].func, directed_rows[r].key,
                              directed_rows[r].fixed,
                              {directed_rows[r].status, directed_rows[r].slot});
            end
            for (int n = 0; n < RANDOM_ITEMS / 3; n++)
            begin
                if (n == RANDOM_ITEMS / 6)
                    drain_results();
                send_random(insert_pct);
            end
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("%0d items in three pacing phases: %0d inserted, %0d found, %0d not found,",
                 items_sent, status_seen[cht_pkg::ST_INSERTED], status_seen[cht_pkg::ST_FOUND],
                 status_seen[cht_pkg::ST_NOT_FOUND]);
        $display("%0d overflow, %0d underflow, %0d removed",
                 status_seen[cht_pkg::ST_OVERFLOW], status_seen[cht_pkg::ST_UNDERFLOW],
                 status_seen[cht_pkg::ST_REMOVED]);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // watchdog
    initial
    begin
        #20000000;
        $display("FAILURE");
        $finish;
    end

endmodule
